### hdl/fcu_pkg.sv
// ----------------------------------------------------------------------------
// fcu_pkg
// Shared constants, types and arithmetic helpers of the fly camera core.
// ----------------------------------------------------------------------------
package fcu_pkg;

   // angles in degrees Q16
   localparam int DEG89  = 5832704;
   localparam int DEG90  = 5898240;
   localparam int DEG180 = 11796480;
   localparam logic [32:0] DEG360_U  = 33'd23592960;
   // 128 full turns, lifts any wrapped sum above zero
   localparam logic [32:0] WRAP_BIAS = 33'd3019898880;

   // CORDIC gain, Q30
   localparam int GAIN_Q30 = 652032874;
   // angle accumulator width and arctangent table index width
   localparam int ZW      = 26;
   localparam int ATAN_IW = 5;

   typedef enum logic {
      OP_ROOT,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } rd_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rd_status_type;

   // arctangent of 2^-i in degrees Q16
   function automatic logic signed [ZW-1:0] atan_deg(input logic [ATAN_IW-1:0] i);
      logic signed [ZW-1:0] a;
      begin
         case (i)
            5'd0:    a = 26'sd2949120;
            5'd1:    a = 26'sd1740967;
            5'd2:    a = 26'sd919879;
            5'd3:    a = 26'sd466945;
            5'd4:    a = 26'sd234379;
            5'd5:    a = 26'sd117304;
            5'd6:    a = 26'sd58666;
            5'd7:    a = 26'sd29335;
            5'd8:    a = 26'sd14668;
            5'd9:    a = 26'sd7334;
            5'd10:   a = 26'sd3667;
            5'd11:   a = 26'sd1833;
            5'd12:   a = 26'sd917;
            5'd13:   a = 26'sd458;
            5'd14:   a = 26'sd229;
            5'd15:   a = 26'sd115;
            5'd16:   a = 26'sd57;
            5'd17:   a = 26'sd29;
            5'd18:   a = 26'sd14;
            5'd19:   a = 26'sd7;
            5'd20:   a = 26'sd4;
            5'd21:   a = 26'sd2;
            5'd22:   a = 26'sd1;
            default: a = 26'sd0;
         endcase
         return a;
      end
   endfunction

   // shift right by s, rounding half away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic [63:0] m;
      begin
         m = v[63] ? 64'(-v) : 64'(v);
         m = (m + (64'd1 << (s - 1))) >> s;
         return v[63] ? -$signed(m) : $signed(m);
      end
   endfunction

   // clamp to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      begin
         if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
         else if (v < -34'sh0_8000_0000) r = -32'sh8000_0000;
         else r = v[31:0];
         return r;
      end
   endfunction

endpackage

### hdl/fcu_root_div.sv
// ----------------------------------------------------------------------------
// fcu_root_div
// Iterative integer square root (one result bit per cycle) and restoring
// divider for the 15 bit normalize quotient (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module fcu_root_div
   import fcu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rd_cmd_type    cmd,
   input  logic [63:0]   operand_a,
   input  logic [31:0]   divisor,
   output rd_status_type status,
   output logic [31:0]   result
);

   op_type      op_ff;
   logic [63:0] x_ff;
   logic [63:0] r_ff;
   logic [63:0] bit_ff;
   logic [31:0] div_ff;
   logic [14:0] q_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [63:0] root_t;
   logic [63:0] div_t;

   assign root_t = r_ff + bit_ff;
   assign div_t  = {32'd0, div_ff} << cnt_ff[3:0];

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            op_ff   <= cmd.op;
            x_ff    <= operand_a;
            r_ff    <= 64'd0;
            bit_ff  <= 64'd1 << 62;
            div_ff  <= divisor;
            q_ff    <= 15'd0;
            cnt_ff  <= (cmd.op == OP_ROOT) ? 5'd31 : 5'd14;
         end else if (busy_ff) begin
            if (op_ff == OP_ROOT) begin
               if (x_ff >= root_t) begin
                  x_ff <= x_ff - root_t;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               if (x_ff >= div_t) begin
                  x_ff              <= x_ff - div_t;
                  q_ff[cnt_ff[3:0]] <= 1'b1;
               end
            end
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = (op_ff == OP_ROOT) ? r_ff[31:0] : {17'd0, q_ff};

endmodule

### hdl/free_fly_camera_update_core.sv
// ----------------------------------------------------------------------------
// free_fly_camera_update_core
// Euler angle fly camera: look items turn yaw and pitch and rebuild the
// front, right and up vectors; move items step the eye along front or right.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  req     | in        | req_valid / req_ready        | mode, button, offsets, dir
//  rsp     | out       | rsp_valid / rsp_ready        | eye, front, right, up
//  csr     | in        | csr_write_enable (no wait)   | index, data
//
//  A look item with the button held runs the shared CORDIC unit and the
//  bit-serial root and divider (three normalizes). A move item runs on the
//  shared multiplier. After reset the vectors are built once while
//  req_ready stays low. A waiting rsp item holds the core only at its end.
// ----------------------------------------------------------------------------
module free_fly_camera_update_core
   import fcu_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic               req_button_held,
   input  logic signed [15:0] req_x_offset,
   input  logic signed [15:0] req_y_offset,
   input  logic [2:0]         req_move_direction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_eye_x,
   output logic signed [31:0] rsp_eye_y,
   output logic signed [31:0] rsp_eye_z,
   output logic signed [15:0] rsp_front_x,
   output logic signed [15:0] rsp_front_y,
   output logic signed [15:0] rsp_front_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_write_data
);

   localparam int CW = $clog2(CORDIC_STEPS);

   localparam logic [2:0] CSR_LOOK_SENS  = 3'd0;
   localparam logic [2:0] CSR_MOVE_SPEED = 3'd1;
   localparam logic [2:0] CSR_WORLD_UP_X = 3'd2;
   localparam logic [2:0] CSR_WORLD_UP_Y = 3'd3;
   localparam logic [2:0] CSR_WORLD_UP_Z = 3'd4;

   localparam logic [2:0] DIR_FORWARD = 3'd0;
   localparam logic [2:0] DIR_BACK    = 3'd1;
   localparam logic [2:0] DIR_LEFT    = 3'd2;
   localparam logic [2:0] DIR_RIGHT   = 3'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LK_MX,
      ST_LK_MY,
      ST_LK_PITCH,
      ST_LK_WRAP,
      ST_VEC_START,
      ST_CY_RUN,
      ST_CP_RUN,
      ST_FR_M0,
      ST_FR_M1,
      ST_FR_M2,
      ST_NM_SQ,
      ST_NM_ROOT,
      ST_NM_RWAIT,
      ST_NM_DIV,
      ST_NM_DWAIT,
      ST_CROSS,
      ST_MOVE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      VEC_FRONT,
      VEC_RIGHT,
      VEC_UP
   } vec_type;

   function automatic logic signed [15:0] pick16(input logic signed [15:0] v0,
                                                 input logic signed [15:0] v1,
                                                 input logic signed [15:0] v2,
                                                 input logic [1:0] i);
      logic signed [15:0] r;
      begin
         case (i)
            2'd0:    r = v0;
            2'd1:    r = v1;
            default: r = v2;
         endcase
         return r;
      end
   endfunction

   // configuration
   logic [15:0]        sens_ff;
   logic [23:0]        speed_ff;
   logic signed [15:0] wu_ff [3];

   // camera state
   logic signed [24:0] yaw_ff;
   logic signed [23:0] pitch_ff;
   logic signed [31:0] eye_ff   [3];
   logic signed [15:0] front_ff [3];
   logic signed [15:0] right_ff [3];
   logic signed [15:0] up_ff    [3];

   // sequencer
   state_type          state_ff;
   logic               boot_ff;
   logic               req_ready_ff;
   logic signed [15:0] dx_ff;
   logic signed [15:0] dy_ff;
   logic [2:0]         dir_ff;
   logic [32:0]        red_ff;
   logic [2:0]         wrap_k_ff;
   logic signed [31:0] cx_ff;
   logic signed [31:0] cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic [CW-1:0]      ccnt_ff;
   logic               flip_ff;
   logic signed [31:0] cos_yaw_ff;
   logic signed [31:0] sin_yaw_ff;
   logic signed [31:0] cos_pitch_ff;
   logic signed [31:0] raw_ff [3];
   logic [63:0]        sum_ff;
   logic [1:0]         nm_idx_ff;
   vec_type            nm_sel_ff;
   logic [31:0]        n_ff;
   logic [2:0]         cr_cnt_ff;
   logic signed [31:0] cr_tmp_ff;
   logic [1:0]         mv_cnt_ff;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_eye_ff   [3];
   logic signed [15:0] rsp_front_ff [3];
   logic signed [15:0] rsp_right_ff [3];
   logic signed [15:0] rsp_up_ff    [3];

   // root / divide unit
   rd_cmd_type         rd_cmd;
   rd_status_type      rd_status;
   logic [63:0]        rd_a;
   logic [31:0]        rd_result;

   // combinational helpers
   logic signed [34:0] wrap_t;
   logic [32:0]        red_in;
   logic signed [33:0] pitch_sum;
   logic signed [23:0] pitch_in;
   logic [32:0]        wrap_sub;
   logic [32:0]        red_step;
   logic signed [24:0] yaw_in;
   logic signed [ZW-1:0] fold_z;
   logic               fold_flip;
   logic signed [ZW-1:0] at_val;
   logic signed [31:0] cx_in;
   logic signed [31:0] cy_in;
   logic signed [ZW-1:0] cz_in;
   logic               cord_last;
   logic signed [31:0] nm_raw;
   logic [31:0]        nm_mag;
   logic signed [15:0] nm_val;
   logic               nm_last;
   logic [1:0]         cr_ai;
   logic [1:0]         cr_bi;
   logic signed [31:0] cr_p;
   logic signed [63:0] mv_step;
   logic signed [33:0] mv_sum;
   logic               mv_add;
   logic               mv_use_front;
   logic [1:0]         mv_k;

   // look arithmetic: yaw wrap, pitch clamp, wrap reduction step
   always_comb begin
      wrap_t = 35'(yaw_ff) + $signed(prod_ff[34:0]) + 35'(DEG180);
      if (wrap_t < 0) wrap_t = wrap_t + $signed({2'b00, WRAP_BIAS});
      red_in = wrap_t[32:0];

      pitch_sum = 34'(pitch_ff) + $signed(prod_ff[33:0]);
      if (pitch_sum > 34'(DEG89)) pitch_in = 24'(DEG89);
      else if (pitch_sum < -34'(DEG89)) pitch_in = -24'(DEG89);
      else pitch_in = pitch_sum[23:0];

      wrap_sub = DEG360_U << wrap_k_ff;
      red_step = (red_ff >= wrap_sub) ? red_ff - wrap_sub : red_ff;
      yaw_in   = 25'($signed({1'b0, red_step}) - 34'(DEG180));
   end

   // yaw folded into +-90 degrees for the CORDIC
   always_comb begin
      fold_flip = 1'b0;
      fold_z    = ZW'(yaw_ff);
      if (yaw_ff > 25'(DEG90)) begin
         fold_z    = ZW'(yaw_ff) - ZW'(DEG180);
         fold_flip = 1'b1;
      end else if (yaw_ff < -25'(DEG90)) begin
         fold_z    = ZW'(yaw_ff) + ZW'(DEG180);
         fold_flip = 1'b1;
      end
   end

   // one CORDIC rotation
   always_comb begin
      at_val = atan_deg(ATAN_IW'(ccnt_ff));
      if (!cz_ff[ZW-1]) begin
         cx_in = cx_ff - (cy_ff >>> ccnt_ff);
         cy_in = cy_ff + (cx_ff >>> ccnt_ff);
         cz_in = cz_ff - at_val;
      end else begin
         cx_in = cx_ff + (cy_ff >>> ccnt_ff);
         cy_in = cy_ff - (cx_ff >>> ccnt_ff);
         cz_in = cz_ff + at_val;
      end
      cord_last = (ccnt_ff == CW'(CORDIC_STEPS - 1));
   end

   // normalize component select
   always_comb begin
      case (nm_idx_ff)
         2'd0:    nm_raw = raw_ff[0];
         2'd1:    nm_raw = raw_ff[1];
         default: nm_raw = raw_ff[2];
      endcase
      nm_mag  = nm_raw[31] ? 32'(-nm_raw) : 32'(nm_raw);
      nm_val  = nm_raw[31] ? -16'(rd_result) : 16'(rd_result);
      nm_last = (nm_idx_ff == 2'd2);
   end

   // cross product operand order and move step
   always_comb begin
      case (cr_cnt_ff)
         3'd0:    begin cr_ai = 2'd1; cr_bi = 2'd2; end
         3'd1:    begin cr_ai = 2'd2; cr_bi = 2'd1; end
         3'd2:    begin cr_ai = 2'd2; cr_bi = 2'd0; end
         3'd3:    begin cr_ai = 2'd0; cr_bi = 2'd2; end
         3'd4:    begin cr_ai = 2'd0; cr_bi = 2'd1; end
         default: begin cr_ai = 2'd1; cr_bi = 2'd0; end
      endcase
      cr_p = prod_ff[31:0];

      mv_use_front = (dir_ff == DIR_FORWARD) || (dir_ff == DIR_BACK);
      mv_add       = (dir_ff == DIR_FORWARD) || (dir_ff == DIR_RIGHT);
      mv_k         = mv_cnt_ff - 2'd1;
      mv_step      = round_shift(prod_ff, 14);
      case (mv_k)
         2'd0:    mv_sum = 34'(eye_ff[0]);
         2'd1:    mv_sum = 34'(eye_ff[1]);
         default: mv_sum = 34'(eye_ff[2]);
      endcase
      mv_sum = mv_add ? mv_sum + $signed(mv_step[33:0]) : mv_sum - $signed(mv_step[33:0]);
   end

   // multiplier operand select
   always_comb begin
      mul_a = 32'sd0;
      mul_b = 32'sd0;
      case (state_ff)
         ST_LK_MX: begin
            mul_a = 32'(dx_ff);
            mul_b = $signed({16'd0, sens_ff});
         end
         ST_LK_MY: begin
            mul_a = 32'(dy_ff);
            mul_b = $signed({16'd0, sens_ff});
         end
         ST_FR_M0: begin
            mul_a = cos_yaw_ff;
            mul_b = cos_pitch_ff;
         end
         ST_FR_M1: begin
            mul_a = sin_yaw_ff;
            mul_b = cos_pitch_ff;
         end
         ST_NM_SQ: begin
            mul_a = nm_raw;
            mul_b = nm_raw;
         end
         ST_CROSS: begin
            if (nm_sel_ff == VEC_RIGHT) begin
               mul_a = 32'(pick16(right_ff[0], right_ff[1], right_ff[2], cr_ai));
               mul_b = 32'(pick16(front_ff[0], front_ff[1], front_ff[2], cr_bi));
            end else begin
               mul_a = 32'(pick16(front_ff[0], front_ff[1], front_ff[2], cr_ai));
               mul_b = 32'(pick16(wu_ff[0], wu_ff[1], wu_ff[2], cr_bi));
            end
         end
         ST_MOVE: begin
            mul_a = mv_use_front ?
                    32'(pick16(front_ff[0], front_ff[1], front_ff[2], mv_cnt_ff)) :
                    32'(pick16(right_ff[0], right_ff[1], right_ff[2], mv_cnt_ff));
            mul_b = $signed({8'd0, speed_ff});
         end
         default: begin
            mul_a = 32'sd0;
            mul_b = 32'sd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // root and divide commands
   always_comb begin
      rd_cmd.start = (state_ff == ST_NM_ROOT) || ((state_ff == ST_NM_DIV) && (n_ff != 32'd0));
      rd_cmd.op    = (state_ff == ST_NM_ROOT) ? OP_ROOT : OP_DIV;
      rd_a         = (state_ff == ST_NM_ROOT) ? sum_ff :
                     ({18'd0, nm_mag, 14'd0} + {33'd0, n_ff[31:1]});
   end

   fcu_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rd_cmd),
      .operand_a (rd_a),
      .divisor   (n_ff),
      .status    (rd_status),
      .result    (rd_result)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= 16'd6554;
         speed_ff <= 24'd3277;
         wu_ff[0] <= 16'sd0;
         wu_ff[1] <= 16'sd16384;
         wu_ff[2] <= 16'sd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOOK_SENS:  sens_ff  <= csr_write_data[15:0];
            CSR_MOVE_SPEED: speed_ff <= csr_write_data;
            CSR_WORLD_UP_X: wu_ff[0] <= csr_write_data[15:0];
            CSR_WORLD_UP_Y: wu_ff[1] <= csr_write_data[15:0];
            CSR_WORLD_UP_Z: wu_ff[2] <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // sequencer: state, camera state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_VEC_START;
         boot_ff      <= 1'b1;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         yaw_ff       <= -25'(DEG90);
         pitch_ff     <= 24'sd0;
         eye_ff[0]    <= 32'sd0;
         eye_ff[1]    <= 32'sd0;
         eye_ff[2]    <= 32'sd0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  dx_ff        <= req_x_offset;
                  dy_ff        <= req_y_offset;
                  dir_ff       <= req_move_direction;
                  mv_cnt_ff    <= 2'd0;
                  if (req_mode) begin
                     state_ff <= (req_move_direction[2] == 1'b0) ? ST_MOVE : ST_DONE;
                  end else begin
                     state_ff <= req_button_held ? ST_LK_MX : ST_DONE;
                  end
               end
            end

            // look: scale offsets, wrap yaw, clamp pitch
            ST_LK_MX: state_ff <= ST_LK_MY;
            ST_LK_MY: begin
               red_ff   <= red_in;
               state_ff <= ST_LK_PITCH;
            end
            ST_LK_PITCH: begin
               pitch_ff  <= pitch_in;
               wrap_k_ff <= 3'd7;
               state_ff  <= ST_LK_WRAP;
            end
            ST_LK_WRAP: begin
               red_ff <= red_step;
               if (wrap_k_ff == 3'd0) begin
                  yaw_ff   <= yaw_in;
                  state_ff <= ST_VEC_START;
               end else begin
                  wrap_k_ff <= wrap_k_ff - 3'd1;
               end
            end

            // sine and cosine of yaw, then of pitch
            ST_VEC_START: begin
               cx_ff    <= 32'(GAIN_Q30);
               cy_ff    <= 32'sd0;
               cz_ff    <= fold_z;
               flip_ff  <= fold_flip;
               ccnt_ff  <= '0;
               state_ff <= ST_CY_RUN;
            end
            ST_CY_RUN: begin
               cx_ff   <= cx_in;
               cy_ff   <= cy_in;
               cz_ff   <= cz_in;
               ccnt_ff <= ccnt_ff + CW'(1);
               if (cord_last) begin
                  cos_yaw_ff <= flip_ff ? -cx_in : cx_in;
                  sin_yaw_ff <= flip_ff ? -cy_in : cy_in;
                  cx_ff      <= 32'(GAIN_Q30);
                  cy_ff      <= 32'sd0;
                  cz_ff      <= ZW'(pitch_ff);
                  ccnt_ff    <= '0;
                  state_ff   <= ST_CP_RUN;
               end
            end
            ST_CP_RUN: begin
               cx_ff   <= cx_in;
               cy_ff   <= cy_in;
               cz_ff   <= cz_in;
               ccnt_ff <= ccnt_ff + CW'(1);
               if (cord_last) begin
                  cos_pitch_ff <= cx_in;
                  raw_ff[1]    <= cy_in;
                  state_ff     <= ST_FR_M0;
               end
            end

            // raw front vector
            ST_FR_M0: state_ff <= ST_FR_M1;
            ST_FR_M1: begin
               raw_ff[0] <= 32'(round_shift(prod_ff, 30));
               state_ff  <= ST_FR_M2;
            end
            ST_FR_M2: begin
               raw_ff[2] <= 32'(round_shift(prod_ff, 30));
               nm_idx_ff <= 2'd0;
               nm_sel_ff <= VEC_FRONT;
               state_ff  <= ST_NM_SQ;
            end

            // normalize: sum of squares, root, three divides
            ST_NM_SQ: begin
               case (nm_idx_ff)
                  2'd0:    sum_ff <= sum_ff;
                  2'd1:    sum_ff <= 64'(prod_ff);
                  default: sum_ff <= sum_ff + 64'(prod_ff);
               endcase
               if (nm_idx_ff == 2'd3) state_ff <= ST_NM_ROOT;
               nm_idx_ff <= nm_idx_ff + 2'd1;
            end
            ST_NM_ROOT: state_ff <= ST_NM_RWAIT;
            ST_NM_RWAIT: begin
               if (rd_status.done) begin
                  n_ff      <= rd_result;
                  nm_idx_ff <= 2'd0;
                  state_ff  <= ST_NM_DIV;
               end
            end
            ST_NM_DIV, ST_NM_DWAIT: begin
               if ((state_ff == ST_NM_DIV && n_ff == 32'd0) ||
                   (state_ff == ST_NM_DWAIT && rd_status.done)) begin
                  case (nm_sel_ff)
                     VEC_FRONT: front_ff[nm_idx_ff] <= (n_ff == 32'd0) ? 16'sd0 : nm_val;
                     VEC_RIGHT: right_ff[nm_idx_ff] <= (n_ff == 32'd0) ? 16'sd0 : nm_val;
                     default:   up_ff[nm_idx_ff]    <= (n_ff == 32'd0) ? 16'sd0 : nm_val;
                  endcase
                  nm_idx_ff <= nm_idx_ff + 2'd1;
                  state_ff  <= ST_NM_DIV;
                  if (nm_last) begin
                     cr_cnt_ff <= 3'd0;
                     if (nm_sel_ff != VEC_UP) begin
                        state_ff <= ST_CROSS;
                     end else if (boot_ff) begin
                        boot_ff      <= 1'b0;
                        req_ready_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
               end else if (state_ff == ST_NM_DIV) begin
                  state_ff <= ST_NM_DWAIT;
               end
            end

            // cross product, two products per component
            ST_CROSS: begin
               if (cr_cnt_ff != 3'd0) begin
                  if (cr_cnt_ff[0]) cr_tmp_ff <= cr_p;
                  else raw_ff[2'(cr_cnt_ff[2:1] - 2'd1)] <= cr_tmp_ff - cr_p;
               end
               cr_cnt_ff <= cr_cnt_ff + 3'd1;
               if (cr_cnt_ff == 3'd6) begin
                  nm_idx_ff <= 2'd0;
                  nm_sel_ff <= (nm_sel_ff == VEC_RIGHT) ? VEC_UP : VEC_RIGHT;
                  state_ff  <= ST_NM_SQ;
               end
            end

            // move: one component per cycle on the multiplier
            ST_MOVE: begin
               if (mv_cnt_ff != 2'd0) eye_ff[mv_k] <= sat32(mv_sum);
               mv_cnt_ff <= mv_cnt_ff + 2'd1;
               if (mv_cnt_ff == 2'd3) state_ff <= ST_DONE;
            end

            // hand the item to the result register
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_eye_ff   <= eye_ff;
                  rsp_front_ff <= front_ff;
                  rsp_right_ff <= right_ff;
                  rsp_up_ff    <= up_ff;
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = req_ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_eye_x   = rsp_eye_ff[0];
   assign rsp_eye_y   = rsp_eye_ff[1];
   assign rsp_eye_z   = rsp_eye_ff[2];
   assign rsp_front_x = rsp_front_ff[0];
   assign rsp_front_y = rsp_front_ff[1];
   assign rsp_front_z = rsp_front_ff[2];
   assign rsp_right_x = rsp_right_ff[0];
   assign rsp_right_y = rsp_right_ff[1];
   assign rsp_right_z = rsp_right_ff[2];
   assign rsp_up_x    = rsp_up_ff[0];
   assign rsp_up_y    = rsp_up_ff[1];
   assign rsp_up_z    = rsp_up_ff[2];

   // pitch always inside the clamp window
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= 24'(DEG89)) && (pitch_ff >= -24'(DEG89)))
      else $error("pitch outside clamp");

   // yaw always wrapped into [-180, 180)
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (yaw_ff >= -25'(DEG180)) && (yaw_ff < 25'(DEG180)))
      else $error("yaw not wrapped");

   // root/divide unit never restarted while running
   a_rd_start: assert property (@(posedge clock) disable iff (reset)
      rd_cmd.start |-> !rd_status.busy)
      else $error("root unit started while busy");

   // unit completion only seen while waiting for it
   a_rd_done: assert property (@(posedge clock) disable iff (reset)
      rd_status.done |-> (state_ff == ST_NM_RWAIT || state_ff == ST_NM_DWAIT))
      else $error("unexpected root unit completion");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while busy");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fly camera core. A scoreboard class tracks yaw,
// pitch, eye and the three unit vectors in 64 bit integer math. It predicts
// one pose per accepted item and checks each returned pose in order. Several
// register settings are exercised, with random gaps on both channels and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import fcu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LIMIT_CYCLES = 4000000;
   localparam int  SETTLE_CYCLES = 400;
   localparam int  HOLD_OFF_CYCLES = 3000;

   // register indexes
   localparam logic [2:0] REG_SENS = 3'd0;
   localparam logic [2:0] REG_SPEED = 3'd1;
   localparam logic [2:0] REG_UP_X = 3'd2;
   localparam logic [2:0] REG_UP_Y = 3'd3;
   localparam logic [2:0] REG_UP_Z = 3'd4;
   // move directions
   localparam logic [2:0] DIR_FWD = 3'd0;
   localparam logic [2:0] DIR_BACK = 3'd1;
   localparam logic [2:0] DIR_LEFT = 3'd2;
   localparam logic [2:0] DIR_RIGHT = 3'd3;
   // item modes
   localparam bit MODE_LOOK = 1'b0;
   localparam bit MODE_MOVE = 1'b1;

   typedef struct {
      bit            mode;
      bit            held;
      shortint       dx;
      shortint       dy;
      bit [2:0]      dir;
   } cam_item_type;

   typedef struct {
      longint eye[3];
      longint fr[3];
      longint rt[3];
      longint upv[3];
   } pose_type;

   // ------------------------------------------------------------------------
   // camera state tracker and pose checker
   // ------------------------------------------------------------------------
   class camera_scoreboard;
      longint  sens, speed;
      longint  wu[3];
      longint  yaw, pitch;
      longint  eye[3], fr[3], rt[3], upv[3];
      pose_type poses_due[$];
      int      errors;
      longint  atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

      function new();
         sens = 6554;
         speed = 3277;
         wu = '{0, 16384, 0};
         yaw = -5898240;
         pitch = 0;
         eye = '{0, 0, 0};
         errors = 0;
         rebuild_axes();
      endfunction

      function void set_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            REG_SENS: sens = val[15:0];
            REG_SPEED: speed = val;
            REG_UP_X: wu[0] = longint'($signed(val[15:0]));
            REG_UP_Y: wu[1] = longint'($signed(val[15:0]));
            REG_UP_Z: wu[2] = longint'($signed(val[15:0]));
            default: ;
         endcase
      endfunction

      function longint rnd_shr(longint v, int s);
         longint unsigned m;
         m = v < 0 ? -v : v;
         m = (m + (64'd1 << (s - 1))) >> s;
         return v < 0 ? -longint'(m) : longint'(m);
      endfunction

      function longint unsigned int_root(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void unit3(longint v[3], output longint o[3]);
         longint unsigned mag[3], sum, n, q;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = v[k] < 0 ? -v[k] : v[k];
            sum += mag[k] * mag[k];
         end
         n = int_root(sum);
         for (int k = 0; k < 3; k++) begin
            q = (n != 0) ? (mag[k] * 16384 + n / 2) / n : 0;
            o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
         end
      endfunction

      function void cross3(longint a[3], longint b[3], output longint o[3]);
         o[0] = a[1] * b[2] - a[2] * b[1];
         o[1] = a[2] * b[0] - a[0] * b[2];
         o[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      // rotation in Q30 with angles in degrees Q16
      function void sin_cos(longint z, output longint c, output longint s);
         longint x, y, nx, ny;
         x = GAIN_Q30;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
            end else begin
               nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
            end
            x = nx;
            y = ny;
         end
         c = x;
         s = y;
      endfunction

      function void rebuild_axes();
         longint cy, sy, cp, sp, z, raw[3];
         bit flip;
         z = yaw;
         flip = 0;
         if (z > DEG90) begin
            z -= DEG180; flip = 1;
         end else if (z < -DEG90) begin
            z += DEG180; flip = 1;
         end
         sin_cos(z, cy, sy);
         if (flip) begin
            cy = -cy; sy = -sy;
         end
         sin_cos(pitch, cp, sp);
         raw[0] = rnd_shr(cy * cp, 30);
         raw[1] = sp;
         raw[2] = rnd_shr(sy * cp, 30);
         unit3(raw, fr);
         cross3(fr, wu, raw);
         unit3(raw, rt);
         cross3(rt, fr, raw);
         unit3(raw, upv);
      endfunction

      function void note_item(cam_item_type it);
         longint t, r, st;
         pose_type p;
         if (it.mode == MODE_LOOK) begin
            if (it.held) begin
               t = yaw + longint'(it.dx) * sens;
               r = (t + DEG180) % 64'sd23592960;
               if (r < 0) r += 23592960;
               yaw = r - DEG180;
               pitch += longint'(it.dy) * sens;
               if (pitch > DEG89) pitch = DEG89;
               if (pitch < -DEG89) pitch = -DEG89;
               rebuild_axes();
            end
         end else if (it.dir < 4) begin
            for (int k = 0; k < 3; k++) begin
               st = rnd_shr((it.dir < 2 ? fr[k] : rt[k]) * speed, 14);
               t = (it.dir == DIR_FWD || it.dir == DIR_RIGHT) ? eye[k] + st : eye[k] - st;
               if (t > 64'sd2147483647) t = 64'sd2147483647;
               if (t < -64'sd2147483648) t = -64'sd2147483648;
               eye[k] = t;
            end
         end
         p.eye = eye;
         p.fr = fr;
         p.rt = rt;
         p.upv = upv;
         poses_due.push_back(p);
      endfunction

      function void cmp(string name, longint e, longint a);
         if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_pose(pose_type a);
         pose_type e;
         if (poses_due.size() == 0) begin
            $error("pose returned with none outstanding");
            errors++;
            return;
         end
         e = poses_due.pop_front();
         cmp("eye_x", e.eye[0], a.eye[0]);
         cmp("eye_y", e.eye[1], a.eye[1]);
         cmp("eye_z", e.eye[2], a.eye[2]);
         cmp("front_x", e.fr[0], a.fr[0]);
         cmp("front_y", e.fr[1], a.fr[1]);
         cmp("front_z", e.fr[2], a.fr[2]);
         cmp("right_x", e.rt[0], a.rt[0]);
         cmp("right_y", e.rt[1], a.rt[1]);
         cmp("right_z", e.rt[2], a.rt[2]);
         cmp("up_x", e.upv[0], a.upv[0]);
         cmp("up_y", e.upv[1], a.upv[1]);
         cmp("up_z", e.upv[2], a.upv[2]);
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_ready, req_mode, req_button_held;
   logic signed [15:0] req_x_offset, req_y_offset;
   logic [2:0]         req_move_direction;
   logic               rsp_valid, rsp_ready;
   logic signed [31:0] rsp_eye_x, rsp_eye_y, rsp_eye_z;
   logic signed [15:0] rsp_front_x, rsp_front_y, rsp_front_z;
   logic signed [15:0] rsp_right_x, rsp_right_y, rsp_right_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [23:0]        csr_write_data;

   camera_scoreboard cam_sb = new();
   int               cycle_count = 0;
   int               hold_left = 0;
   bit               no_gaps = 0;

   free_fly_camera_update_core DUT (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side: random stalls plus the long hold-off
   initial begin
      pose_type got;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.eye = '{rsp_eye_x, rsp_eye_y, rsp_eye_z};
            got.fr = '{rsp_front_x, rsp_front_y, rsp_front_z};
            got.rt = '{rsp_right_x, rsp_right_y, rsp_right_z};
            got.upv = '{rsp_up_x, rsp_up_y, rsp_up_z};
            cam_sb.check_pose(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= (pick_gap() == 0);
         end
      end
   end

   task automatic send_item(cam_item_type it);
      int gap;
      req_mode <= it.mode;
      req_button_held <= it.held;
      req_x_offset <= it.dx;
      req_y_offset <= it.dy;
      req_move_direction <= it.dir;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      cam_sb.note_item(it);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic look(bit held, shortint dx, shortint dy);
      cam_item_type it;
      it = '{MODE_LOOK, held, dx, dy, 3'($urandom)};
      send_item(it);
   endtask

   task automatic move(logic [2:0] dir);
      cam_item_type it;
      it = '{MODE_MOVE, 1'($urandom), shortint'($urandom), shortint'($urandom), dir};
      send_item(it);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      cam_sb.set_reg(idx, val);
   endtask

   // drain all poses, then let the core settle before touching registers
   task automatic drain();
      req_valid <= 0;
      while (cam_sb.poses_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] s, logic [23:0] sp, logic [15:0] ux,
                           logic [15:0] uy, logic [15:0] uz);
      drain();
      csr_write(REG_SENS, {8'h00, s});
      csr_write(REG_SPEED, sp);
      csr_write(REG_UP_X, 24'($signed(ux)));
      csr_write(REG_UP_Y, 24'($signed(uy)));
      csr_write(REG_UP_Z, 24'($signed(uz)));
      csr_write_enable <= 0;
   endtask

   // random traffic; move_pct sets the share of move items, fwd_bias pushes
   // moves forward so the eye runs into saturation
   task automatic random_items(int count, int move_pct, bit fwd_bias);
      cam_item_type it;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         it.mode = ($urandom_range(0, 99) < move_pct) ? MODE_MOVE : MODE_LOOK;
         it.held = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 3) == 0) begin
            it.dx = shortint'($urandom);
            it.dy = shortint'($urandom);
         end else begin
            it.dx = shortint'($urandom_range(0, 200)) - 16'sd100;
            it.dy = shortint'($urandom_range(0, 200)) - 16'sd100;
         end
         it.dir = (fwd_bias && $urandom_range(0, 9) < 8) ? DIR_FWD : 3'($urandom);
         send_item(it);
      end
      no_gaps = 0;
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_mode = 0;
      req_button_held = 0;
      req_x_offset = 0;
      req_y_offset = 0;
      req_move_direction = 0;
      csr_write_enable = 0;
      csr_index = 0;
      csr_write_data = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: reset pose, released button, extremes, clamps, every direction
      look(0, 16'sh7FFF, -16'sh8000);
      look(1, 0, 0);
      for (int d = 0; d < 8; d++) move(3'(d));
      look(1, 16'sh7FFF, 16'sh7FFF);
      look(1, -16'sh8000, -16'sh8000);
      look(1, 900, 0);
      look(1, -1800, 300);
      look(1, 1, -1);
      move(DIR_FWD);
      move(DIR_RIGHT);
      look(0, 50, 50);

      // extremes of the registers; world up zero gives degenerate axes
      set_regs(16'hFFFF, 24'hFFFFFF, 16'sd0, 16'sd16384, 16'sd0);
      random_items(260, 85, 1);
      set_regs(16'h0000, 24'h000000, 16'sd16384, 16'sd0, 16'sd0);
      random_items(120, 40, 0);
      set_regs(16'd6554, 24'd3277, 16'sd0, 16'sd0, 16'sd0);
      look(1, 10, 10);
      move(DIR_RIGHT);
      random_items(100, 40, 0);
      set_regs(16'd1000, 24'd65536, -16'sd32768, 16'sh7FFF, -16'sd16384);
      random_items(240, 50, 0);
      // writes past the register list must be ignored
      drain();
      csr_write(3'd5, 24'hFFFFFF);
      csr_write(3'd6, 24'h123456);
      csr_write(3'd7, 24'hABCDEF);
      csr_write_enable <= 0;
      set_regs(16'd6554, 24'd3277, 16'sd0, 16'sd16384, 16'sd0);
      random_items(200, 50, 0);

      // receiver stops for a long stretch while items keep coming
      hold_left = HOLD_OFF_CYCLES;
      random_items(60, 60, 0);

      for (int ph = 0; ph < 5; ph++) begin
         set_regs(16'($urandom), 24'($urandom_range(0, 200000)),
                  16'($signed(16'($urandom_range(0, 32768)) - 16'sd16384)),
                  16'($signed(16'($urandom_range(0, 32768)) - 16'sd16384)),
                  16'($signed(16'($urandom_range(0, 32768)) - 16'sd16384)));
         random_items(190, 50, 0);
      end

      drain();
      if (cam_sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
